### src/assert_macros.svh
// Assertion macros shared by the RTL modules.
// Expects clk and arst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Property checked at every rising edge outside reset.
`define ASSERT_CLK(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("assertion failed");
// Condition that never holds outside reset.
`define ASSERT_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
	else $error("forbidden condition");
`endif

### src/grwc_pkg.sv
// Shared types, constants and trig table for the grid raycast wall column block.
// No dependencies.
package grwc_pkg;

	localparam int CW    = 36;
	localparam int DW    = 46;
	localparam int TW    = 23;
	localparam int PW    = 62;
	localparam int QW    = 21;
	localparam int DIVW  = 56;
	localparam int D28W  = 48;

	localparam logic [63:0]         WALL_MAP_RESET = 64'hFF81_8995_8981_81FF;
	localparam logic signed [DW-1:0] NO_HIT        = 46'sd26843545600000;
	localparam logic [DIVW-1:0]     HEIGHT_NUM     = 56'h0000_0500_0000_0000;
	localparam logic [8:0]          HEIGHT_MAX     = 9'd320;
	localparam logic [8:0]          HALF_SCREEN    = 9'd160;
	localparam logic [4:0]          TAN_STEPS      = 5'd21;
	localparam logic [4:0]          HEIGHT_STEPS   = 5'd9;

	typedef enum logic [4:0] {
		OP_NONE, OP_LOAD, OP_RAY, OP_TSET, OP_TQUO, OP_TMUL, OP_TINIT, OP_WALK,
		OP_DIST1, OP_DIST2, OP_TEND, OP_CORR, OP_D28, OP_HSET, OP_HQUO, OP_OUT,
		OP_NEXT
	} dp_op_t;

	typedef enum logic [4:0] {
		S_IDLE, S_RAY, S_TSET, S_TDIV, S_TMUL, S_TINIT, S_WALK, S_DIST1, S_DIST2,
		S_TEND, S_CORR, S_D28, S_HSET, S_HDIV, S_OUT, S_SEND
	} state_t;

	typedef struct packed {
		dp_op_t op;
		logic   div_start;
	} cmd_t;

	typedef struct packed {
		logic near;
		logic tsat;
		logic hit;
		logic walk_last;
		logic vtr;
		logic hfix;
		logic last_ray;
	} status_t;

	typedef struct packed {
		logic [DIVW-1:0] num;
		logic [DIVW-1:0] ds;
		logic [4:0]      steps;
	} div_req_t;

	function automatic logic [14:0] quarter_sine(input logic [6:0] i);
		logic [14:0] v;
		case (i)
			7'd0: v = 15'd0;       7'd1: v = 15'd286;     7'd2: v = 15'd572;
			7'd3: v = 15'd857;     7'd4: v = 15'd1143;    7'd5: v = 15'd1428;
			7'd6: v = 15'd1713;    7'd7: v = 15'd1997;    7'd8: v = 15'd2280;
			7'd9: v = 15'd2563;    7'd10: v = 15'd2845;   7'd11: v = 15'd3126;
			7'd12: v = 15'd3406;   7'd13: v = 15'd3686;   7'd14: v = 15'd3964;
			7'd15: v = 15'd4240;   7'd16: v = 15'd4516;   7'd17: v = 15'd4790;
			7'd18: v = 15'd5063;   7'd19: v = 15'd5334;   7'd20: v = 15'd5604;
			7'd21: v = 15'd5872;   7'd22: v = 15'd6138;   7'd23: v = 15'd6402;
			7'd24: v = 15'd6664;   7'd25: v = 15'd6924;   7'd26: v = 15'd7182;
			7'd27: v = 15'd7438;   7'd28: v = 15'd7692;   7'd29: v = 15'd7943;
			7'd30: v = 15'd8192;   7'd31: v = 15'd8438;   7'd32: v = 15'd8682;
			7'd33: v = 15'd8923;   7'd34: v = 15'd9162;   7'd35: v = 15'd9397;
			7'd36: v = 15'd9630;   7'd37: v = 15'd9860;   7'd38: v = 15'd10087;
			7'd39: v = 15'd10311;  7'd40: v = 15'd10531;  7'd41: v = 15'd10749;
			7'd42: v = 15'd10963;  7'd43: v = 15'd11174;  7'd44: v = 15'd11381;
			7'd45: v = 15'd11585;  7'd46: v = 15'd11786;  7'd47: v = 15'd11982;
			7'd48: v = 15'd12176;  7'd49: v = 15'd12365;  7'd50: v = 15'd12551;
			7'd51: v = 15'd12733;  7'd52: v = 15'd12911;  7'd53: v = 15'd13085;
			7'd54: v = 15'd13255;  7'd55: v = 15'd13421;  7'd56: v = 15'd13583;
			7'd57: v = 15'd13741;  7'd58: v = 15'd13894;  7'd59: v = 15'd14044;
			7'd60: v = 15'd14189;  7'd61: v = 15'd14330;  7'd62: v = 15'd14466;
			7'd63: v = 15'd14598;  7'd64: v = 15'd14726;  7'd65: v = 15'd14849;
			7'd66: v = 15'd14968;  7'd67: v = 15'd15082;  7'd68: v = 15'd15191;
			7'd69: v = 15'd15296;  7'd70: v = 15'd15396;  7'd71: v = 15'd15491;
			7'd72: v = 15'd15582;  7'd73: v = 15'd15668;  7'd74: v = 15'd15749;
			7'd75: v = 15'd15826;  7'd76: v = 15'd15897;  7'd77: v = 15'd15964;
			7'd78: v = 15'd16026;  7'd79: v = 15'd16083;  7'd80: v = 15'd16135;
			7'd81: v = 15'd16182;  7'd82: v = 15'd16225;  7'd83: v = 15'd16262;
			7'd84: v = 15'd16294;  7'd85: v = 15'd16322;  7'd86: v = 15'd16344;
			7'd87: v = 15'd16362;  7'd88: v = 15'd16374;  7'd89: v = 15'd16382;
			7'd90: v = 15'd16384;
			default: v = 15'd0;
		endcase
		return v;
	endfunction

	function automatic logic signed [15:0] sin_q(input logic [8:0] d);
		logic [6:0]  i;
		logic        neg;
		logic [15:0] m;
		neg = 1'b0;
		if (d <= 9'd90) begin
			i = d[6:0];
		end else if (d <= 9'd180) begin
			i = 7'(9'd180 - d);
		end else if (d <= 9'd270) begin
			i = 7'(d - 9'd180);
			neg = 1'b1;
		end else begin
			i = 7'(9'd360 - d);
			neg = 1'b1;
		end
		m = {1'b0, quarter_sine(i)};
		return neg ? $signed(-m) : $signed(m);
	endfunction

	function automatic logic signed [15:0] cos_q(input logic [8:0] d);
		logic [9:0] e;
		e = {1'b0, d} + 10'd90;
		if (e >= 10'd360) begin
			e = e - 10'd360;
		end
		return sin_q(e[8:0]);
	endfunction

endpackage

### src/grwc_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on grwc_pkg.
module grwc_div import grwc_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  div_req_t       req,
	output logic           busy,
	output logic [QW-1:0]  quo
);

	logic [DIVW-1:0] rem_q;
	logic [DIVW-1:0] ds_q;
	logic [QW-1:0]   quo_q;
	logic [4:0]      cnt_q;
	logic            busy_q;
	logic            ge;

	assign ge = rem_q >= ds_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= req.steps;
		end else if (busy_q) begin
			cnt_q  <= cnt_q - 5'd1;
			busy_q <= cnt_q != 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= req.num;
			ds_q  <= req.ds;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? rem_q - ds_q : rem_q;
			ds_q  <= ds_q >> 1;
			quo_q <= {quo_q[QW-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;

endmodule

### src/grwc_dp.sv
// Datapath: ray angle, trace setup, grid walk, distance, fisheye and height.
// Depends on grwc_pkg; the divider sits beside it at the top level.
module grwc_dp import grwc_pkg::*; #(
	parameter int NUM_RAYS  = 60,
	parameter int MAX_STEPS = 8,
	parameter int MAP_DIM   = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	input  logic                cfg_we,
	input  logic [63:0]         cfg_wdata,
	input  logic [15:0]         player_x,
	input  logic [15:0]         player_y,
	input  logic [8:0]          view_angle,
	input  logic [QW-1:0]       div_quo,
	output div_req_t            div_req,
	output status_t             status,
	output logic [5:0]          column,
	output logic signed [15:0]  hit_x,
	output logic signed [15:0]  hit_y,
	output logic                hit_vertical,
	output logic [16:0]         wall_distance,
	output logic [8:0]          wall_height,
	output logic [7:0]          wall_top,
	output logic                last
);

	localparam int KW = $clog2(MAX_STEPS + 1);

	logic [63:0]            wall_map_q;
	logic [15:0]            px_q, py_q;
	logic [8:0]             ra_q;
	logic [5:0]             r_q;
	logic signed [15:0]     c_q, s_q, cc_q;
	logic                   vtr_q;
	logic signed [TW-1:0]   t_q;
	logic signed [24:0]     prim0_q;
	logic signed [PW-1:0]   prod_q;
	logic signed [CW-1:0]   xr_q, yr_q, dx_q, dy_q, vx_q, vy_q, bx_q, by_q;
	logic signed [DW-1:0]   tdist_q, vd_q, bd_q;
	logic                   bvert_q;
	logic [KW-1:0]          k_q;
	logic signed [D28W-1:0] d28_q;
	logic [8:0]             height_q;

	logic [8:0]             vam, start_a, ca;
	logic signed [15:0]     den, numr, aden16, anum16;
	logic [14:0]            aden, anum;
	logic                   tneg, fwd, near, tsat, hit, hnonpos, hsat;
	logic [2:0]             cellp;
	logic signed [24:0]     pp, prim0, diff;
	logic signed [CW-1:0]   p36, q36, ps36, sec0, dsec, t6, dprim;
	logic signed [47:0]     mul_t;
	logic signed [24:0]     xd, yd;
	logic signed [40:0]     m_c, m_s;
	logic signed [PW-1:0]   m_corr;
	logic signed [TW-1:0]   qs;
	logic signed [21:0]     bxs, bys;
	logic [19:0]            dwhole;

	function automatic logic [15:0] sat16(input logic signed [21:0] v);
		logic [15:0] o;
		if (v > 22'sd32767) begin
			o = 16'h7FFF;
		end else if (v < -22'sd32768) begin
			o = 16'h8000;
		end else begin
			o = v[15:0];
		end
		return o;
	endfunction

	always_comb begin
		vam     = (view_angle >= 9'd360) ? view_angle - 9'd360 : view_angle;
		start_a = (vam >= 9'd330) ? vam - 9'd330 : vam + 9'd30;
		ca      = (r_q < 6'd30) ? {3'd0, r_q} + 9'd330 : {3'd0, r_q} - 9'd30;
		den     = vtr_q ? c_q : s_q;
		numr    = vtr_q ? s_q : c_q;
		aden16  = den[15] ? -den : den;
		anum16  = numr[15] ? -numr : numr;
		aden    = aden16[14:0];
		anum    = anum16[14:0];
		tneg    = den[15] ^ numr[15];
		near    = aden <= 15'd16;
		tsat    = {7'd0, anum} >= {aden, 7'd0};
		fwd     = vtr_q ? !den[15] : den[15];
		cellp   = vtr_q ? px_q[15:13] : py_q[15:13];
		p36     = $signed({13'd0, px_q, 7'd0});
		q36     = $signed({13'd0, py_q, 7'd0});
		pp      = vtr_q ? $signed({2'd0, px_q, 7'd0}) : $signed({2'd0, py_q, 7'd0});
		ps36    = vtr_q ? q36 : p36;
		prim0   = fwd ? $signed({1'b0, {1'b0, cellp} + 4'd1, 20'd0})
		              : $signed({2'd0, cellp, 20'd0}) - 25'sd1;
		diff    = pp - prim0_q;
		mul_t   = diff * t_q;
		sec0    = prod_q[49:14] + ps36;
		t6      = {{7{t_q[TW-1]}}, t_q, 6'd0};
		dsec    = fwd ? -t6 : t6;
		dprim   = fwd ? 36'sd1048576 : -36'sd1048576;
		hit     = !xr_q[35] && !yr_q[35] && (xr_q[34:20] < 15'(MAP_DIM)) &&
		          (yr_q[34:20] < 15'(MAP_DIM)) && ((xr_q[22:20] | yr_q[22:20]) != 3'd0) &&
		          wall_map_q[{yr_q[22:20], xr_q[22:20]}];
		xd      = 25'(xr_q - p36);
		yd      = 25'(yr_q - q36);
		m_c     = c_q * xd;
		m_s     = s_q * yd;
		m_corr  = bd_q * cc_q;
		hnonpos = d28_q[D28W-1] || (d28_q == '0);
		hsat    = {d28_q[D28W-2:0], 9'd0} <= HEIGHT_NUM;
		qs      = $signed({2'd0, div_quo});
		bxs     = bx_q[35:14];
		bys     = by_q[35:14];
		dwhole  = d28_q[47:28];
	end

	always_comb begin
		if (cmd.op == OP_HSET) begin
			div_req.num   = HEIGHT_NUM;
			div_req.ds    = {d28_q, 8'd0};
			div_req.steps = HEIGHT_STEPS;
		end else begin
			div_req.num   = {27'd0, anum, 14'd0};
			div_req.ds    = {21'd0, aden, 20'd0};
			div_req.steps = TAN_STEPS;
		end
	end

	assign status.near      = near;
	assign status.tsat      = tsat;
	assign status.hit       = hit;
	assign status.walk_last = k_q == KW'(MAX_STEPS - 1);
	assign status.vtr       = vtr_q;
	assign status.hfix      = hnonpos || hsat;
	assign status.last_ray  = r_q == 6'(NUM_RAYS - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wall_map_q <= WALL_MAP_RESET;
			r_q        <= '0;
			vtr_q      <= 1'b1;
			k_q        <= '0;
		end else begin
			if (cfg_we) begin
				wall_map_q <= cfg_wdata;
			end
			case (cmd.op)
				OP_LOAD:  r_q   <= '0;
				OP_NEXT:  r_q   <= r_q + 6'd1;
				OP_RAY:   vtr_q <= 1'b1;
				OP_TEND:  vtr_q <= 1'b0;
				OP_TINIT: k_q   <= '0;
				OP_WALK:  k_q   <= hit ? k_q : k_q + KW'(1);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				px_q <= player_x;
				py_q <= player_y;
				ra_q <= start_a;
			end
			OP_NEXT: ra_q <= (ra_q == 9'd0) ? 9'd359 : ra_q - 9'd1;
			OP_RAY: begin
				c_q  <= cos_q(ra_q);
				s_q  <= sin_q(ra_q);
				cc_q <= cos_q(ca);
			end
			OP_TSET: begin
				prim0_q <= prim0;
				t_q     <= tneg ? -23'sd2097152 : 23'sd2097152;
				if (near) begin
					xr_q    <= p36;
					yr_q    <= q36;
					tdist_q <= NO_HIT;
				end
			end
			OP_TQUO: t_q <= tneg ? -qs : qs;
			OP_TMUL: prod_q <= {{14{mul_t[47]}}, mul_t};
			OP_TINIT: begin
				if (vtr_q) begin
					xr_q <= CW'(prim0_q);
					yr_q <= sec0;
					dx_q <= dprim;
					dy_q <= dsec;
				end else begin
					yr_q <= CW'(prim0_q);
					xr_q <= sec0;
					dy_q <= dprim;
					dx_q <= dsec;
				end
			end
			OP_WALK: begin
				if (!hit) begin
					xr_q    <= xr_q + dx_q;
					yr_q    <= yr_q + dy_q;
					tdist_q <= NO_HIT;
				end
			end
			OP_DIST1: prod_q  <= {{21{m_c[40]}}, m_c};
			OP_DIST2: tdist_q <= prod_q[DW-1:0] - {{5{m_s[40]}}, m_s};
			OP_TEND: begin
				if (vtr_q) begin
					vx_q <= xr_q;
					vy_q <= yr_q;
					vd_q <= tdist_q;
				end else if (vd_q < tdist_q) begin
					bx_q    <= vx_q;
					by_q    <= vy_q;
					bd_q    <= vd_q;
					bvert_q <= 1'b1;
				end else begin
					bx_q    <= xr_q;
					by_q    <= yr_q;
					bd_q    <= tdist_q;
					bvert_q <= 1'b0;
				end
			end
			OP_CORR: prod_q <= m_corr;
			OP_D28:  d28_q  <= prod_q[61:14];
			OP_HSET: height_q <= HEIGHT_MAX;
			OP_HQUO: height_q <= (div_quo > QW'(HEIGHT_MAX)) ? HEIGHT_MAX : div_quo[8:0];
			OP_OUT: begin
				column        <= r_q;
				hit_x         <= sat16(bxs);
				hit_y         <= sat16(bys);
				hit_vertical  <= bvert_q;
				wall_distance <= hnonpos ? 17'd0 :
				                 (dwhole > 20'd131071) ? 17'd131071 : dwhole[16:0];
				wall_height   <= height_q;
				wall_top      <= 8'(HALF_SCREEN - {1'b0, height_q[8:1]});
				last          <= r_q == 6'(NUM_RAYS - 1);
			end
			default: ;
		endcase
	end

endmodule

### src/grwc_ctrl.sv
// Controller state machine sequencing the datapath and the divider.
// Depends on grwc_pkg and assert_macros.svh.
`include "assert_macros.svh"
module grwc_ctrl import grwc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  status_t st,
	input  logic    div_busy,
	output cmd_t    cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		cmd.op        = OP_NONE;
		cmd.div_start = 1'b0;
		in_ready      = 1'b0;
		out_valid     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = S_RAY;
				end
			end
			S_RAY: begin
				cmd.op  = OP_RAY;
				state_d = S_TSET;
			end
			S_TSET: begin
				cmd.op = OP_TSET;
				if (st.near) begin
					state_d = S_TEND;
				end else if (st.tsat) begin
					state_d = S_TMUL;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = S_TDIV;
				end
			end
			S_TDIV: begin
				if (!div_busy) begin
					cmd.op  = OP_TQUO;
					state_d = S_TMUL;
				end
			end
			S_TMUL: begin
				cmd.op  = OP_TMUL;
				state_d = S_TINIT;
			end
			S_TINIT: begin
				cmd.op  = OP_TINIT;
				state_d = S_WALK;
			end
			S_WALK: begin
				cmd.op = OP_WALK;
				if (st.hit) begin
					state_d = S_DIST1;
				end else if (st.walk_last) begin
					state_d = S_TEND;
				end
			end
			S_DIST1: begin
				cmd.op  = OP_DIST1;
				state_d = S_DIST2;
			end
			S_DIST2: begin
				cmd.op  = OP_DIST2;
				state_d = S_TEND;
			end
			S_TEND: begin
				cmd.op  = OP_TEND;
				state_d = st.vtr ? S_TSET : S_CORR;
			end
			S_CORR: begin
				cmd.op  = OP_CORR;
				state_d = S_D28;
			end
			S_D28: begin
				cmd.op  = OP_D28;
				state_d = S_HSET;
			end
			S_HSET: begin
				cmd.op = OP_HSET;
				if (st.hfix) begin
					state_d = S_OUT;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = S_HDIV;
				end
			end
			S_HDIV: begin
				if (!div_busy) begin
					cmd.op  = OP_HQUO;
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				cmd.op  = OP_OUT;
				state_d = S_SEND;
			end
			S_SEND: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (st.last_ray) begin
						state_d = S_IDLE;
					end else begin
						cmd.op  = OP_NEXT;
						state_d = S_RAY;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	`ASSERT_CLK(a_div_starts, cmd.div_start |=> div_busy)
	`ASSERT_NEVER(a_in_out_excl, in_ready && out_valid)
	`ASSERT_CLK(a_frame_end, (out_valid && out_ready && st.last_ray) |=> in_ready)

endmodule

### src/grid_raycast_wall_columns.sv
// Grid raycast wall column generator: one input frame request, one result per ray.
// Instantiates grwc_ctrl, grwc_dp and grwc_div; depends on grwc_pkg.
//
// Usage:
//   s_axis carries a frame request (player position Q9.7, view angle in degrees).
//   m_axis returns NUM_RAYS transfers, one wall column per ray, tlast on the final
//   ray. cfg_we/cfg_wdata load the 64-bit wall map; write only while idle.
// Sequence:
//   Per ray one table lookup, then per trace a tangent division in the shared
//   divider and up to MAX_STEPS grid steps, then fisheye correction and a height
//   division in the same divider. s_axis_tready is high only between frames.
// Reset:
//   arst_n clears the controller to idle and loads the default wall map.
// Stall:
//   A result is held on m_axis until taken; work on the next ray waits for it.
module grid_raycast_wall_columns import grwc_pkg::*; #(
	parameter int NUM_RAYS  = 60,
	parameter int MAX_STEPS = 8,
	parameter int MAP_DIM   = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [63:0] cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// player_x [15:0], player_y [31:16], view_angle [40:32], zero fill
	input  logic [47:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// column [5:0], hit_x [21:6], hit_y [37:22], wall_distance [54:38],
	// wall_height [63:55], wall_top [71:64]
	output logic [71:0] m_axis_tdata,
	// hit_vertical [0]
	output logic [0:0]  m_axis_tuser,
	output logic        m_axis_tlast
);

	cmd_t              cmd;
	status_t           st;
	div_req_t          div_req;
	logic              div_busy;
	logic [QW-1:0]     div_quo;
	logic [5:0]        column;
	logic signed [15:0] hit_x, hit_y;
	logic              hit_vertical;
	logic [16:0]       wall_distance;
	logic [8:0]        wall_height;
	logic [7:0]        wall_top;

	grwc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.st        (st),
		.div_busy  (div_busy),
		.cmd       (cmd)
	);

	grwc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.req    (div_req),
		.busy   (div_busy),
		.quo    (div_quo)
	);

	grwc_dp #(
		.NUM_RAYS  (NUM_RAYS),
		.MAX_STEPS (MAX_STEPS),
		.MAP_DIM   (MAP_DIM)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.player_x      (s_axis_tdata[15:0]),
		.player_y      (s_axis_tdata[31:16]),
		.view_angle    (s_axis_tdata[40:32]),
		.div_quo       (div_quo),
		.div_req       (div_req),
		.status        (st),
		.column        (column),
		.hit_x         (hit_x),
		.hit_y         (hit_y),
		.hit_vertical  (hit_vertical),
		.wall_distance (wall_distance),
		.wall_height   (wall_height),
		.wall_top      (wall_top),
		.last          (m_axis_tlast)
	);

	assign m_axis_tdata = {wall_top, wall_height, wall_distance, hit_y, hit_x, column};
	assign m_axis_tuser = hit_vertical;

endmodule

### sim/tb_top.sv
// Self-checking testbench for grid_raycast_wall_columns: frame requests in, wall columns out.
// Predicts every column with an in-bench raycaster and checks each transfer field by field.
// Depends on the RTL top level only (grwc_pkg comes in through it).
module tb_top;

	localparam int RAYS      = 60;
	localparam int STEPS     = 8;
	localparam int DIM       = 8;
	localparam int IDLE_MAX  = 60000;
	localparam int HOLD_LEN  = 3000;
	localparam int SETTLE    = 16;
	localparam logic [63:0] MAP_DEFAULT = 64'hFF81_8995_8981_81FF;

	typedef enum logic [0:0] {K_FRAME, K_MAP} job_kind_t;

	typedef struct {
		job_kind_t   kind;
		logic        drain;
		logic [15:0] px;
		logic [15:0] py;
		logic [8:0]  va;
		logic [63:0] map;
	} job_t;

	typedef struct packed {
		logic [5:0]  column;
		logic [15:0] hit_x;
		logic [15:0] hit_y;
		logic        vert;
		logic [16:0] wdist;
		logic [8:0]  height;
		logic [7:0]  top;
		logic        last;
	} wall_col_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [63:0] cfg_wdata;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [71:0] m_axis_tdata;
	logic [0:0]  m_axis_tuser;
	logic        m_axis_tlast;

	job_t      pending[$];
	wall_col_t columns_due[$];
	logic [63:0] map_now;
	int  frames_in, offered, mismatches, idle_cycles, settle_cnt, cols_seen;
	int  tx_gap, rx_gap, hold_cnt;
	bit  tx_busy, quiet, hold_done, gen_done;

	grid_raycast_wall_columns dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	function automatic longint sine_q14(int d);
		int qs[91] = '{
			0, 286, 572, 857, 1143, 1428, 1713, 1997, 2280, 2563,
			2845, 3126, 3406, 3686, 3964, 4240, 4516, 4790, 5063, 5334,
			5604, 5872, 6138, 6402, 6664, 6924, 7182, 7438, 7692, 7943,
			8192, 8438, 8682, 8923, 9162, 9397, 9630, 9860, 10087, 10311,
			10531, 10749, 10963, 11174, 11381, 11585, 11786, 11982, 12176, 12365,
			12551, 12733, 12911, 13085, 13255, 13421, 13583, 13741, 13894, 14044,
			14189, 14330, 14466, 14598, 14726, 14849, 14968, 15082, 15191, 15296,
			15396, 15491, 15582, 15668, 15749, 15826, 15897, 15964, 16026, 16083,
			16135, 16182, 16225, 16262, 16294, 16322, 16344, 16362, 16374, 16382,
			16384};
		int a;
		a = d % 360;
		if (a <= 90) return qs[a];
		if (a <= 180) return qs[180 - a];
		if (a <= 270) return -qs[a - 180];
		return -qs[360 - a];
	endfunction

	function automatic longint clip(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint trace_cells(inout longint x, inout longint y,
			input longint dx, input longint dy, input longint c, input longint s,
			input longint ox, input longint oy, input logic [63:0] map);
		longint mx, my;
		for (int k = 0; k < STEPS; k++) begin
			mx = x >>> 20;
			my = y >>> 20;
			if (mx >= 0 && mx < DIM && my >= 0 && my < DIM && (mx | my) != 0 &&
					map[my * 8 + mx])
				return c * (x - ox) - s * (y - oy);
			x += dx;
			y += dy;
		end
		return 64'sd100000 <<< 28;
	endfunction

	task automatic cast_frame(logic [15:0] px, logic [15:0] py, logic [8:0] va_in,
			logic [63:0] map);
		longint p, q, xb, yb, c, s, t, vx, vy, hx, hy, dv, dh, ex, ey, dd, d28, h;
		int va, ra;
		bit vert;
		wall_col_t w;
		va = va_in % 360;
		p = longint'(px) <<< 7;
		q = longint'(py) <<< 7;
		xb = ((longint'(px) >> 7) >> 6) << 6;
		yb = ((longint'(py) >> 7) >> 6) << 6;
		for (int r = 0; r < RAYS; r++) begin
			ra = (va + 30 + 360 - r) % 360;
			c = sine_q14(ra + 90);
			s = sine_q14(ra);
			vx = p; vy = q; hx = p; hy = q;
			dv = 64'sd100000 <<< 28;
			dh = dv;
			if (c > 16 || c < -16) begin
				t = clip(s * 16384 / c, -128 * 16384, 128 * 16384);
				vx = c > 0 ? ((xb + 64) <<< 14) : ((xb <<< 14) - 1);
				vy = (((p - vx) * t) >>> 14) + q;
				dv = trace_cells(vx, vy, c > 0 ? (64 <<< 14) : -(64 <<< 14),
					-64 * t * (c > 0 ? 1 : -1), c, s, p, q, map);
			end
			if (s > 16 || s < -16) begin
				t = clip(c * 16384 / s, -128 * 16384, 128 * 16384);
				hy = s > 0 ? ((yb <<< 14) - 1) : ((yb + 64) <<< 14);
				hx = (((q - hy) * t) >>> 14) + p;
				dh = trace_cells(hx, hy, 64 * t * (s > 0 ? 1 : -1),
					s > 0 ? -(64 <<< 14) : (64 <<< 14), c, s, p, q, map);
			end
			vert = dv < dh;
			ex = vert ? vx : hx;
			ey = vert ? vy : hy;
			dd = vert ? dv : dh;
			d28 = (dd * sine_q14((va + 360 - ra) % 360 + 90)) >>> 14;
			h = d28 <= 0 ? 320 : clip((64'sd5 <<< 40) / d28, 0, 320);
			w.column = 6'(r);
			w.hit_x = 16'(clip(ex >>> 14, -32768, 32767));
			w.hit_y = 16'(clip(ey >>> 14, -32768, 32767));
			w.vert = vert;
			w.wdist = d28 <= 0 ? 17'd0 : 17'(clip(d28 >>> 28, 0, 131071));
			w.height = 9'(h);
			w.top = 8'(160 - (h >> 1));
			w.last = r == RAYS - 1;
			columns_due.push_back(w);
		end
	endtask

	task automatic add_frame(logic [15:0] px, logic [15:0] py, logic [8:0] va, bit drain);
		job_t j;
		j.kind = K_FRAME; j.drain = drain; j.px = px; j.py = py; j.va = va; j.map = '0;
		pending.push_back(j);
	endtask

	task automatic add_map(logic [63:0] m);
		job_t j;
		j.kind = K_MAP; j.drain = 1'b1; j.px = '0; j.py = '0; j.va = '0; j.map = m;
		pending.push_back(j);
	endtask

	task automatic add_random(int n);
		logic [15:0] px, py;
		for (int i = 0; i < n; i++) begin
			px = 16'($urandom);
			py = 16'($urandom);
			if ($urandom_range(0, 9) == 0) begin
				px = {9'($urandom_range(0, 9)), 7'd0};
				py = {9'($urandom_range(0, 9)), 7'd0};
			end
			add_frame(px, py, 9'($urandom_range(0, 511)), $urandom_range(0, 15) == 0);
		end
	endtask

	// Stimulus: directed frames, then random frames over several wall maps.
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		gen_done = 1'b0;
		add_frame(16'h0000, 16'h0000, 9'd0, 1'b0);
		add_frame(16'hFFFF, 16'hFFFF, 9'd359, 1'b0);
		add_frame(16'hFFFF, 16'h0000, 9'd90, 1'b0);
		add_frame(16'h0000, 16'hFFFF, 9'd180, 1'b0);
		add_frame(16'd32768, 16'd32768, 9'd270, 1'b0);
		add_frame(16'd32768, 16'd32768, 9'd360, 1'b0);
		add_frame(16'd32768, 16'd32768, 9'd511, 1'b0);
		add_frame(16'd4096, 16'd4096, 9'd45, 1'b0);
		add_frame(16'd8192, 16'd24576, 9'd135, 1'b1);
		add_frame(16'd12345, 16'd54321, 9'd225, 1'b0);
		add_frame(16'd8192, 16'd8192, 9'd315, 1'b0);
		add_frame(16'd40000, 16'd20000, 9'd120, 1'b0);
		add_map(64'hFFFF_FFFF_FFFF_FFFF);
		add_frame(16'd4000, 16'd4000, 9'd0, 1'b0);
		add_frame(16'd33000, 16'd9000, 9'd200, 1'b0);
		add_map(64'h0);
		add_frame(16'd32768, 16'd32768, 9'd10, 1'b0);
		add_frame(16'd100, 16'd100, 9'd300, 1'b0);
		add_random(40);
		add_map($urandom_range(0, 32'hFFFF_FFFF) | (64'($urandom) << 32));
		add_random(60);
		add_map(64'hFFFF_FFFF_FFFF_FFFF);
		add_random(40);
		add_map({$urandom, $urandom} & {$urandom, $urandom});
		add_random(60);
		add_map(MAP_DEFAULT);
		add_random(50);
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		gen_done = 1'b1;
		wait (pending.size() == 0 && !tx_busy && columns_due.size() == 0);
		repeat (300) @(posedge clk);
		if (mismatches == 0 && columns_due.size() == 0)
			$display("grid_raycast_wall_columns regression: pass");
		else
			$display("grid_raycast_wall_columns regression: fail");
		$finish;
	end

	// Driver: frame requests and map writes, changed on the falling edge.
	always @(negedge clk) begin
		job_t j;
		logic we;
		we = 1'b0;
		if (arst_n && gen_done) begin
			if (tx_busy) begin
				if (frames_in == offered) begin
					s_axis_tvalid <= 1'b0;
					tx_busy = 1'b0;
					tx_gap = quiet ? 0 : $urandom_range(0, 17);
				end
			end else if (tx_gap > 0) begin
				tx_gap--;
			end else if (pending.size() != 0) begin
				j = pending[0];
				if (!j.drain || (columns_due.size() == 0 && settle_cnt >= SETTLE)) begin
					void'(pending.pop_front());
					if (j.kind == K_MAP) begin
						we = 1'b1;
						cfg_wdata <= j.map;
					end else begin
						s_axis_tdata <= {7'd0, j.va, j.py, j.px};
						s_axis_tvalid <= 1'b1;
						offered++;
						tx_busy = 1'b1;
					end
				end
			end
		end
		cfg_we <= we;
	end

	// Receiver: random back-pressure, quiet frames, and one long hold.
	always @(negedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (hold_cnt > 0) begin
			hold_cnt--;
			m_axis_tready <= 1'b0;
		end else if (rx_gap > 0) begin
			rx_gap--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Monitor: predict on accepted requests, check accepted columns.
	always @(posedge clk) begin
		wall_col_t w, got;
		bit moved;
		if (!arst_n) begin
			map_now <= MAP_DEFAULT;
			frames_in = 0; offered = 0; mismatches = 0; idle_cycles = 0;
			settle_cnt = 0; cols_seen = 0; tx_gap = 0; rx_gap = 0; hold_cnt = 0;
			tx_busy = 1'b0; quiet = 1'b0; hold_done = 1'b0;
		end else begin
			moved = 1'b0;
			if (cfg_we) map_now <= cfg_wdata;
			if (s_axis_tvalid && s_axis_tready) begin
				cast_frame(s_axis_tdata[15:0], s_axis_tdata[31:16], s_axis_tdata[40:32],
					map_now);
				frames_in++;
				quiet = (frames_in % 7) == 3;
				moved = 1'b1;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				moved = 1'b1;
				cols_seen++;
				got.column = m_axis_tdata[5:0];
				got.hit_x = m_axis_tdata[21:6];
				got.hit_y = m_axis_tdata[37:22];
				got.wdist = m_axis_tdata[54:38];
				got.height = m_axis_tdata[63:55];
				got.top = m_axis_tdata[71:64];
				got.vert = m_axis_tuser[0];
				got.last = m_axis_tlast;
				if (columns_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected column transfer: column %0d", got.column);
				end else begin
					w = columns_due.pop_front();
					if (w != got) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"column mismatch: expected col %0d x %0d y %0d v %0d ",
								"d %0d h %0d t %0d l %0d, got col %0d x %0d y %0d v %0d ",
								"d %0d h %0d t %0d l %0d"},
								w.column, $signed(w.hit_x), $signed(w.hit_y), w.vert,
								w.wdist, w.height, w.top, w.last,
								got.column, $signed(got.hit_x), $signed(got.hit_y),
								got.vert, got.wdist, got.height, got.top, got.last);
					end
				end
				rx_gap = quiet ? 0 : $urandom_range(0, 17);
				if (!hold_done && frames_in == 4 && got.column == 20) begin
					hold_cnt = HOLD_LEN;
					hold_done = 1'b1;
				end
			end
			if (columns_due.size() == 0 && !s_axis_tvalid)
				settle_cnt++;
			else
				settle_cnt = 0;
			idle_cycles = moved ? 0 : idle_cycles + 1;
			if (idle_cycles >= IDLE_MAX) begin
				$display("grid_raycast_wall_columns regression: fail");
				$finish;
			end
		end
	end

endmodule
